### hw/rtl/sha256_byte_stream_hasher_defines.svh
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher: assertion macros
// Shared property forms for the hasher's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SHABS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hasher check failed");

// next-cycle implication, sampled on clk, off during reset
`define SHABS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hasher check failed");

`endif

### hw/rtl/shabs_pkg.sv
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Word types, round constants, initial hash and sequencer states.
// ---------------------------------------------------------------------------
package shabs_pkg;

  typedef logic [31:0] word_t;
  // eight working or hash words, element 0 is a / H0
  typedef logic [7:0][31:0] hvec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_UPDATE,
    S_EMIT
  } state_t;

  // input beat commands on in_tuser[0]
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam hvec_t H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

### hw/rtl/shabs_round.sv
// ---------------------------------------------------------------------------
// SHA-256 round unit
// One compression round plus one message schedule word, used once a cycle.
// ---------------------------------------------------------------------------
module shabs_round
  import shabs_pkg::*;
(
  input  hvec_t v_i,     // working words a..h
  input  word_t w_t,     // W[t]
  input  word_t w_t1,    // W[t+1]
  input  word_t w_t9,    // W[t+9]
  input  word_t w_t14,   // W[t+14]
  input  word_t k_i,     // K[t]
  output hvec_t v_o,     // working words after the round
  output word_t w_o      // W[t+16]
);

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  word_t a, e, t1, t2, sum1, sum0, ch, maj, sig0, sig1;

  // round datapath
  always_comb begin
    a    = v_i[0];
    e    = v_i[4];
    sum1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    sum0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    ch   = (e & v_i[5]) ^ (~e & v_i[6]);
    maj  = (a & v_i[1]) ^ (a & v_i[2]) ^ (v_i[1] & v_i[2]);
    t1   = v_i[7] + sum1 + ch + k_i + w_t;
    t2   = sum0 + maj;
    v_o    = {v_i[6:4], v_i[3] + t1, v_i[2:0], t1 + t2};
  end

  // schedule expansion
  always_comb begin
    sig0 = rotr(w_t1, 7) ^ rotr(w_t1, 18) ^ (w_t1 >> 3);
    sig1 = rotr(w_t14, 17) ^ rotr(w_t14, 19) ^ (w_t14 >> 10);
    w_o  = w_t + sig0 + w_t9 + sig1;
  end

endmodule

### hw/rtl/sha256_byte_stream_hasher.sv
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Absorbs message bytes, pads on finish and streams out the 256-bit digest.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats carry one message byte in in_tdata[7:0] with in_tuser[0] = 0
//   (absorb), or in_tuser[0] = 1 (finish, data ignored).
//   After finish the digest leaves as eight 32-bit beats on out_tdata, H0
//   first, with the word position on out_tuser and out_tlast on the eighth.
// Sequencing:
//   An absorb beat is taken while idle; the beat that fills a 64-byte block
//   then runs the compression rounds on the single shared round unit and
//   then the hash update. A finish writes padding bytes from the held count
//   to the end of the block, then runs rounds and update, and padding, rounds
//   and update once more for a length block when more than 55 bytes were
//   held, then the eight output beats. in_tready is low whenever a block or
//   the digest is in progress.
// Reset:
//   rst_n low loads the initial hash, clears the byte count and bit count.
// Stall:
//   Each digest beat holds until out_tready; nothing else advances. After
//   the last beat the hasher is re-initialized for the next message.
// ---------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_defines.svh"

module sha256_byte_stream_hasher
  import shabs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast
);

  state_t            state_r, state_nxt;
  hvec_t             h_r, h_nxt;
  hvec_t             v_r, v_nxt;
  logic [15:0][31:0] w_r, w_nxt;
  logic [5:0]        fill_r, fill_nxt;
  logic [63:0]       bits_r, bits_nxt;
  logic [5:0]        pos_r, pos_nxt;
  logic [5:0]        rnd_r, rnd_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic              fin_r, fin_nxt;
  logic              len_r, len_nxt;
  logic              first_r, first_nxt;

  hvec_t             v_rnd;
  word_t             w_new;
  logic              in_acc, out_acc;
  logic [7:0]        len_byte, pad_byte;

  shabs_round u_round (
    .v_i   (v_r),
    .w_t   (w_r[0]),
    .w_t1  (w_r[1]),
    .w_t9  (w_r[9]),
    .w_t14 (w_r[14]),
    .k_i   (K_TAB[rnd_r]),
    .v_o   (v_rnd),
    .w_o   (w_new)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_EMIT);
  assign out_tdata  = h_r[0];
  assign out_tuser  = idx_r;
  assign out_tlast  = (idx_r == 3'd7);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;

  // padding byte: marker, big-endian length, or zero
  always_comb begin
    len_byte = bits_r[{~pos_r[2:0], 3'b000} +: 8];
    if (first_r) begin
      pad_byte = PAD_MARK;
    end else if (len_r && pos_r >= 6'd56) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // sequencer and datapath next state
  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    v_nxt     = v_r;
    w_nxt     = w_r;
    fill_nxt  = fill_r;
    bits_nxt  = bits_r;
    pos_nxt   = pos_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    fin_nxt   = fin_r;
    len_nxt   = len_r;
    first_nxt = first_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == CMD_ABSORB) begin
            w_nxt[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] = in_tdata;
            fill_nxt = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              bits_nxt  = bits_r + 64'd512;
              v_nxt     = h_r;
              rnd_nxt   = 6'd0;
              state_nxt = S_ROUND;
            end
          end else begin
            bits_nxt  = bits_r + {55'd0, fill_r, 3'b000};
            pos_nxt   = fill_r;
            first_nxt = 1'b1;
            fin_nxt   = 1'b1;
            len_nxt   = (fill_r <= 6'd55);
            fill_nxt  = 6'd0;
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        w_nxt[pos_r[5:2]][{~pos_r[1:0], 3'b000} +: 8] = pad_byte;
        first_nxt = 1'b0;
        pos_nxt   = pos_r + 6'd1;
        if (pos_r == 6'd63) begin
          v_nxt     = h_r;
          rnd_nxt   = 6'd0;
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        v_nxt   = v_rnd;
        w_nxt   = {w_new, w_r[15:1]};
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        if (!fin_r) begin
          state_nxt = S_IDLE;
        end else if (!len_r) begin
          // extra block carries the length
          len_nxt   = 1'b1;
          pos_nxt   = 6'd0;
          state_nxt = S_PAD;
        end else begin
          idx_nxt   = 3'd0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_acc) begin
          h_nxt   = {h_r[0], h_r[7:1]};
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            h_nxt     = H_INIT;
            bits_nxt  = 64'd0;
            fin_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and hash state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      h_r     <= H_INIT;
      fill_r  <= 6'd0;
      bits_r  <= 64'd0;
      pos_r   <= 6'd0;
      rnd_r   <= 6'd0;
      idx_r   <= 3'd0;
      fin_r   <= 1'b0;
      len_r   <= 1'b0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      h_r     <= h_nxt;
      fill_r  <= fill_nxt;
      bits_r  <= bits_nxt;
      pos_r   <= pos_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
      len_r   <= len_nxt;
      first_r <= first_nxt;
    end
  end

  // block window and working words
  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    v_r <= v_nxt;
  end

  // checks
  `SHABS_ASSERT_IMP(a_no_overlap, out_tvalid, !in_tready)
  `SHABS_ASSERT_IMP(a_last_pos, out_tvalid && out_tlast, out_tuser == 3'd7)
  `SHABS_ASSERT_NXT(a_finish_pads, in_acc && in_tuser[0] == CMD_FINISH, state_r == S_PAD)
  `SHABS_ASSERT_NXT(a_round_end, state_r == S_ROUND && rnd_r == 6'd63, state_r == S_UPDATE)
  `SHABS_ASSERT_NXT(a_reinit, out_tvalid && out_tready && out_tlast,
                    in_tready && fill_r == 6'd0 && bits_r == 64'd0)

endmodule

### tb/sha256_byte_stream_hasher_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Streams whole messages (absorb beats ended by a finish beat) into the
// hasher under random input bursts and output stalls. A scoreboard class
// carries its own SHA-256 engine and checks each digest beat in order.
// ---------------------------------------------------------------------------
module sha256_byte_stream_hasher_tb
  import shabs_pkg::*;
();

  localparam int RANDOM_BEATS   = 91;
  localparam int MIN_DIGESTS    = 5;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] CHAIN_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // one expected digest beat
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  // -------------------------------------------------------------------------
  // Scoreboard: running SHA-256 state plus queue of pending digest beats
  // -------------------------------------------------------------------------
  class sha256_digest_tracker;
    logic [31:0]  chain_h [8];
    logic [7:0]   block_buf [64];
    logic [5:0]   byte_fill;
    logic [63:0]  length_bits;
    digest_beat_t pending_words [$];
    int           errors;
    int           words_checked;
    int           two_block_finishes;

    function new();
      errors = 0;
      words_checked = 0;
      two_block_finishes = 0;
      restart();
      foreach (block_buf[i]) block_buf[i] = 8'h00;
    endfunction

    function void restart();
      foreach (chain_h[i]) chain_h[i] = CHAIN_IV[i];
      byte_fill = 6'd0;
      length_bits = 64'd0;
    endfunction

    function logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // 64-round compression of block_buf into chain_h
    function void compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++)
        w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      for (int i = 16; i < 64; i++) begin
        s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = chain_h[i];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
        t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
    endfunction

    // pad, append length, compress, queue the eight digest words
    function void finish_message();
      int pos;
      pos = int'(byte_fill);
      length_bits = length_bits + 64'(pos) * 64'd8;
      block_buf[pos] = 8'h80;
      pos = pos + 1;
      // no room for the length field: spill into a second block
      if (pos > 56) begin
        while (pos < 64) begin
          block_buf[pos] = 8'h00;
          pos = pos + 1;
        end
        compress_block();
        two_block_finishes++;
        pos = 0;
      end
      while (pos < 56) begin
        block_buf[pos] = 8'h00;
        pos = pos + 1;
      end
      for (int i = 0; i < 8; i++) block_buf[56+i] = length_bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++)
        pending_words.push_back('{chain_h[i], 3'(i), (i == 7)});
      restart();
    endfunction

    // called for every accepted input beat
    function void note_beat(logic cmd, logic [7:0] data);
      if (cmd == CMD_ABSORB) begin
        block_buf[byte_fill] = data;
        byte_fill = byte_fill + 6'd1;
        if (byte_fill == 6'd0) begin
          compress_block();
          length_bits = length_bits + 64'd512;
        end
      end else begin
        finish_message();
      end
    endfunction

    // called for every accepted output beat
    function void check_word(logic [31:0] word, logic [2:0] index, logic last);
      digest_beat_t exp;
      words_checked++;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest beat: expected none, actual word=%h index=%0d last=%0d",
                 $time, word, index, last);
        return;
      end
      exp = pending_words.pop_front();
      if (word !== exp.word) begin
        errors++;
        $display("%0t: digest word mismatch: expected %h, actual %h", $time, exp.word, word);
      end
      if (index !== exp.index) begin
        errors++;
        $display("%0t: word index mismatch: expected %0d, actual %0d", $time, exp.index, index);
      end
      if (last !== exp.last) begin
        errors++;
        $display("%0t: last flag mismatch: expected %0d, actual %0d", $time, exp.last, last);
      end
    endfunction

    function int pending();
      return pending_words.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT and stimulus signals
  // -------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic [0:0]  in_tuser = 1'b0;    // [0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [31:0] digest_word
  logic [2:0]  out_tuser;          // [2:0] word_index
  logic        out_tlast;

  sha256_byte_stream_hasher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  sha256_digest_tracker tracker;

  int  beats_sent = 0;
  int  messages_sent = 0;
  int  bytes_sent = 0;
  int  longest_message = 0;
  int  burst_left = 0;
  int  idle_cycles = 0;
  bit  hold_armed = 1'b0;
  bit  hold_done = 1'b0;

  // -------------------------------------------------------------------------
  // Sender: one beat, then either stay valid or open a random gap
  // -------------------------------------------------------------------------
  task automatic send_beat(input logic cmd, input logic [7:0] data);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    tracker.note_beat(cmd, data);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(40, 80))
                                               : int'($urandom_range(0, 7));
    end
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_beat(CMD_ABSORB, 8'($urandom_range(0, 255)));
    // data on a finish beat is don't-care, so drive noise
    send_beat(CMD_FINISH, 8'($urandom_range(0, 255)));
    messages_sent++;
    bytes_sent += len;
    if (len > longest_message) longest_message = len;
  endtask

  // -------------------------------------------------------------------------
  // Receiver ready: random 32-bit ready patterns, one long hold-off
  // -------------------------------------------------------------------------
  initial begin : sink_ready
    logic [31:0] stall_bits;
    int          bit_pos;
    stall_bits = 32'hffff_ffff;
    bit_pos = 0;
    forever begin
      @(posedge clk);
      if (rst_n && hold_armed && !hold_done && out_tvalid) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (bit_pos == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_bits = 32'hffff_ffff;
            1:       stall_bits = $urandom;
            2:       stall_bits = $urandom | $urandom;
            default: stall_bits = $urandom & $urandom;
          endcase
        end
        out_tready <= stall_bits[bit_pos];
        bit_pos = (bit_pos + 1) % 32;
      end
    end
  end

  // check every accepted digest beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_word(out_tdata, out_tuser, out_tlast);
  end

  // watchdog on cycles with no beat accepted on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles, %0d digest words outstanding",
               $time, WATCHDOG_LIMIT, tracker.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : main_seq
    int random_start;
    int digests_at_start;
    int len;
    int pick;
    int remaining;
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message twice, single extreme bytes, "abc", walking one
    send_beat(CMD_FINISH, 8'hff);
    send_beat(CMD_FINISH, 8'h00);
    send_beat(CMD_ABSORB, 8'h00);
    send_beat(CMD_FINISH, 8'h00);
    send_beat(CMD_ABSORB, 8'hff);
    send_beat(CMD_FINISH, 8'hff);
    send_beat(CMD_ABSORB, 8'h61);
    send_beat(CMD_ABSORB, 8'h62);
    send_beat(CMD_ABSORB, 8'h63);
    send_beat(CMD_FINISH, 8'h5a);
    for (int i = 0; i < 8; i++) send_beat(CMD_ABSORB, 8'(1 << i));
    send_beat(CMD_FINISH, 8'ha5);
    messages_sent += 6;
    bytes_sent += 13;
    longest_message = 8;

    // random messages, weighted toward the padding boundaries
    hold_armed = 1'b1;
    random_start = beats_sent;
    digests_at_start = messages_sent;
    while (beats_sent - random_start < RANDOM_BEATS ||
           messages_sent - digests_at_start < MIN_DIGESTS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5)
        len = $urandom_range(0, 10);
      else if (pick <= 7)
        len = $urandom_range(54, 57);    // one- vs two-block padding
      else if (pick == 8)
        len = $urandom_range(62, 66);    // around a full block
      else
        len = $urandom_range(67, 130);   // multi-block
      // keep the total beat count near the budget
      remaining = RANDOM_BEATS - (beats_sent - random_start) - 1;
      if (len > remaining) len = (remaining > 0) ? remaining : 0;
      send_message(len);
    end
    if (in_tvalid) in_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d messages, %0d message bytes (longest %0d), %0d needing a spill block.",
             messages_sent, bytes_sent, longest_message, tracker.two_block_finishes);
    $display("Checked %0d digest words over %0d input beats, with a %0d-cycle output hold.",
             tracker.words_checked, beats_sent, HOLD_CYCLES);
    if (tracker.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
